@@ hdl/kcgd_pkg.sv @@
// ----------------------------------------------------------------------------
// kcgd_pkg
// Shared types and constants for the key click gesture detector.
// ----------------------------------------------------------------------------
package kcgd_pkg;

  localparam int unsigned MaxKeys     = 4;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned CfgW        = 16;
  localparam int unsigned CountW      = 8;
  localparam int unsigned PaddrW      = 3;
  localparam int unsigned PdataW      = 32;
  localparam int unsigned DefNumKeys  = 4;

  localparam logic [CfgW-1:0] RepeatWindowRst  = 16'd300;
  localparam logic [CfgW-1:0] LongPressTimeRst = 16'd3000;

  // Register index, taken from paddr bit 2 (byte address 4*i).
  localparam logic RegRepeatWindow  = 1'b0;
  localparam logic RegLongPressTime = 1'b1;

  // What one key lane reports for one tick.
  typedef struct packed {
    logic              click;
    logic              lng;
    logic              multi;
    logic              held;
    logic              awake;
    logic [CountW-1:0] count;
  } lane_res_t;

  typedef struct packed {
    logic [CfgW-1:0] repeat_window;
    logic [CfgW-1:0] long_press_time;
  } cfg_t;

endpackage

@@ hdl/kcgd_lane.sv @@
// ----------------------------------------------------------------------------
// kcgd_lane
// Gesture state machine of one key: released, pressed, waiting, long press.
// ----------------------------------------------------------------------------
module kcgd_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  logic [kcgd_pkg::TimeW-1:0]           now_ms_i,
  input  logic                                 level_i,
  input  kcgd_pkg::cfg_t                       cfg_i,
  output kcgd_pkg::lane_res_t                  res_o
);

  typedef enum logic [1:0] {
    PhReleased = 2'd0,
    PhPressed  = 2'd1,
    PhWaiting  = 2'd2,
    PhLong     = 2'd3
  } phase_e;

  phase_e                            phase_q, phase_d;
  logic [kcgd_pkg::TimeW-1:0]        ref_q, ref_d;
  logic [kcgd_pkg::CountW-1:0]       cnt_q, cnt_d;
  logic [kcgd_pkg::TimeW-1:0]        delta;
  logic                              long_hit;
  logic                              in_window;
  kcgd_pkg::lane_res_t               res;

  // Elapsed time since the reference, modulo 2^32.
  assign delta     = now_ms_i - ref_q;
  assign long_hit  = delta >= {{(kcgd_pkg::TimeW-kcgd_pkg::CfgW){1'b0}}, cfg_i.long_press_time};
  assign in_window = delta <= {{(kcgd_pkg::TimeW-kcgd_pkg::CfgW){1'b0}}, cfg_i.repeat_window};

  always_comb begin
    phase_d = phase_q;
    ref_d   = ref_q;
    cnt_d   = cnt_q;
    res     = '0;
    case (phase_q)
      PhReleased: begin
        if (level_i) begin
          phase_d = PhPressed;
          ref_d   = now_ms_i;
        end
      end
      PhPressed: begin
        res.held = 1'b1;
        if (!level_i) begin
          phase_d = PhWaiting;
          ref_d   = now_ms_i;
        end else if (long_hit) begin
          phase_d = PhLong;
          res.lng = 1'b1;
        end
      end
      PhWaiting: begin
        res.awake = 1'b1;
        if (level_i && in_window) begin
          phase_d = PhPressed;
          if (cnt_q != '1) begin
            cnt_d = cnt_q + kcgd_pkg::CountW'(1);
          end
        end else if (!in_window) begin
          if (cnt_q != '0) begin
            res.multi = 1'b1;
            res.count = cnt_q;
          end else begin
            res.click = 1'b1;
          end
          cnt_d   = '0;
          phase_d = PhReleased;
        end
      end
      PhLong: begin
        res.awake = 1'b1;
        if (!level_i) begin
          phase_d = PhReleased;
          ref_d   = now_ms_i;
        end
      end
      default: begin
        phase_d = PhReleased;
      end
    endcase
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhReleased;
      ref_q   <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      ref_q   <= ref_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ hdl/kcgd_merge.sv @@
// ----------------------------------------------------------------------------
// kcgd_merge
// Gathers the lane results into one word and holds it in the output register.
// ----------------------------------------------------------------------------
module kcgd_merge (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        load_i,
  input  kcgd_pkg::lane_res_t [kcgd_pkg::MaxKeys-1:0] lane_i,
  input  logic                                        out_stall_i,
  output logic                                        out_valid_o,
  output logic                                        busy_o,
  output logic [kcgd_pkg::MaxKeys-1:0]                click_mask_o,
  output logic [kcgd_pkg::MaxKeys-1:0]                long_mask_o,
  output logic [kcgd_pkg::MaxKeys-1:0]                multi_mask_o,
  output logic [kcgd_pkg::MaxKeys-1:0]                held_mask_o,
  output logic [kcgd_pkg::MaxKeys-1:0]                awake_mask_o,
  output logic [kcgd_pkg::MaxKeys-1:0][kcgd_pkg::CountW-1:0] count_o
);

  logic                                            valid_q;
  logic [kcgd_pkg::MaxKeys-1:0]                    click_q, lng_q, multi_q, held_q, awake_q;
  logic [kcgd_pkg::MaxKeys-1:0]                    click_d, lng_d, multi_d, held_d, awake_d;
  logic [kcgd_pkg::MaxKeys-1:0][kcgd_pkg::CountW-1:0] count_q, count_d;

  always_comb begin
    for (int k = 0; k < kcgd_pkg::MaxKeys; k++) begin
      click_d[k] = lane_i[k].click;
      lng_d[k]   = lane_i[k].lng;
      multi_d[k] = lane_i[k].multi;
      held_d[k]  = lane_i[k].held;
      awake_d[k] = lane_i[k].awake;
      count_d[k] = lane_i[k].count;
    end
  end

  // The register is full and the receiver does not take it this cycle.
  assign busy_o = valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      click_q <= click_d;
      lng_q   <= lng_d;
      multi_q <= multi_d;
      held_q  <= held_d;
      awake_q <= awake_d;
      count_q <= count_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign click_mask_o = click_q;
  assign long_mask_o  = lng_q;
  assign multi_mask_o = multi_q;
  assign held_mask_o  = held_q;
  assign awake_mask_o = awake_q;
  assign count_o      = count_q;

endmodule

@@ hdl/key_click_gesture_detector_top.sv @@
// ----------------------------------------------------------------------------
// key_click_gesture_detector_top
// Click, multi-click and long-press detection for up to four keys.
// ----------------------------------------------------------------------------
// Each input word is one poll tick: a wrapping millisecond timestamp and the
// pressed level of every key. It is accepted when in_valid_i is high and
// in_stall_o is low. Every tick produces exactly one output word carrying
// the per-key click, long-press and multi-click flags, the re-press counts,
// and the held and awake masks.
// The word appears on the output register at the edge that accepts the
// tick. One tick per cycle is sustained while the receiver does not stall;
// each key has its own lane, so all keys are updated in the same cycle, and
// the rate is set by the single output register stage.
// When the receiver raises out_stall_i while a word is waiting, in_stall_o
// rises in the same cycle and the key state freezes until the word is taken;
// a new tick is accepted in the very cycle the waiting word leaves.
// The two timing registers sit on an APB-style port at byte addresses 0
// (repeat_window) and 4 (long_press_time); only paddr bit 2 is decoded.
// Reset puts every key into the released phase with a zero reference time
// and counter, loads the default timings and empties the output register.
// Keys at or above NUM_KEYS have no lane and always report zero.
// ----------------------------------------------------------------------------
module key_click_gesture_detector_top #(
  parameter int unsigned NUM_KEYS = kcgd_pkg::DefNumKeys
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Tick input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [kcgd_pkg::TimeW-1:0]          now_ms_i,
  input  logic [kcgd_pkg::MaxKeys-1:0]        key_levels_i,
  // Result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [kcgd_pkg::MaxKeys-1:0]        click_mask_o,
  output logic [kcgd_pkg::MaxKeys-1:0]        long_mask_o,
  output logic [kcgd_pkg::MaxKeys-1:0]        multi_mask_o,
  output logic [kcgd_pkg::CountW-1:0]         repeat_count_0_o,
  output logic [kcgd_pkg::CountW-1:0]         repeat_count_1_o,
  output logic [kcgd_pkg::CountW-1:0]         repeat_count_2_o,
  output logic [kcgd_pkg::CountW-1:0]         repeat_count_3_o,
  output logic [kcgd_pkg::MaxKeys-1:0]        held_mask_o,
  output logic [kcgd_pkg::MaxKeys-1:0]        awake_mask_o,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [kcgd_pkg::PaddrW-1:0]         paddr,
  input  logic [kcgd_pkg::PdataW-1:0]         pwdata,
  output logic [kcgd_pkg::PdataW-1:0]         prdata,
  output logic                                pready
);

  kcgd_pkg::cfg_t                                 cfg_q;
  logic                                           cfg_wr;
  logic                                           accept;
  logic                                           stall;
  kcgd_pkg::lane_res_t [kcgd_pkg::MaxKeys-1:0]    lane_res;
  logic [kcgd_pkg::MaxKeys-1:0][kcgd_pkg::CountW-1:0] counts;

  // Configuration registers. The access phase always completes at once.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_window   <= kcgd_pkg::RepeatWindowRst;
      cfg_q.long_press_time <= kcgd_pkg::LongPressTimeRst;
    end else if (cfg_wr) begin
      case (paddr[2])
        kcgd_pkg::RegRepeatWindow:  cfg_q.repeat_window   <= pwdata[kcgd_pkg::CfgW-1:0];
        kcgd_pkg::RegLongPressTime: cfg_q.long_press_time <= pwdata[kcgd_pkg::CfgW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      kcgd_pkg::RegRepeatWindow:
        prdata = {{(kcgd_pkg::PdataW-kcgd_pkg::CfgW){1'b0}}, cfg_q.repeat_window};
      kcgd_pkg::RegLongPressTime:
        prdata = {{(kcgd_pkg::PdataW-kcgd_pkg::CfgW){1'b0}}, cfg_q.long_press_time};
      default:
        prdata = '0;
    endcase
  end

  // A tick is taken whenever the output register is free or being emptied.
  assign in_stall_o = stall;
  assign accept     = in_valid_i && !stall;

  // One lane per key in use; unused key positions report nothing.
  for (genvar k = 0; k < kcgd_pkg::MaxKeys; k++) begin : g_lane
    if (k < NUM_KEYS) begin : g_used
      kcgd_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .step_i   (accept),
        .now_ms_i (now_ms_i),
        .level_i  (key_levels_i[k]),
        .cfg_i    (cfg_q),
        .res_o    (lane_res[k])
      );
    end else begin : g_unused
      assign lane_res[k] = '0;
    end
  end

  kcgd_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .lane_i       (lane_res),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .busy_o       (stall),
    .click_mask_o (click_mask_o),
    .long_mask_o  (long_mask_o),
    .multi_mask_o (multi_mask_o),
    .held_mask_o  (held_mask_o),
    .awake_mask_o (awake_mask_o),
    .count_o      (counts)
  );

  assign repeat_count_0_o = counts[0];
  assign repeat_count_1_o = counts[1];
  assign repeat_count_2_o = counts[2];
  assign repeat_count_3_o = counts[3];

endmodule

@@ hdl/kcgd_checker.sv @@
// ----------------------------------------------------------------------------
// kcgd_checker
// Port-level checks of the key click gesture detector, bound to the top level.
// ----------------------------------------------------------------------------
module kcgd_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [kcgd_pkg::MaxKeys-1:0]        click_mask_o,
  input logic [kcgd_pkg::MaxKeys-1:0]        long_mask_o,
  input logic [kcgd_pkg::MaxKeys-1:0]        multi_mask_o,
  input logic [kcgd_pkg::CountW-1:0]         repeat_count_0_o,
  input logic [kcgd_pkg::CountW-1:0]         repeat_count_1_o,
  input logic [kcgd_pkg::CountW-1:0]         repeat_count_2_o,
  input logic [kcgd_pkg::CountW-1:0]         repeat_count_3_o,
  input logic [kcgd_pkg::MaxKeys-1:0]        held_mask_o,
  input logic [kcgd_pkg::MaxKeys-1:0]        awake_mask_o
);

  // A stalled output word stays valid, with its click, multi and long masks unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(click_mask_o)
      && $stable(multi_mask_o) && $stable(long_mask_o))
    else $error("stalled output word changed");

  // Every accepted tick yields a word in the next cycle.
  a_tick_to_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted tick produced no output word");

  // A key is never both held and awake, and a long press starts only when held.
  a_phase_masks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((held_mask_o & awake_mask_o) == '0)
      && ((long_mask_o & ~held_mask_o) == '0))
    else $error("held, awake and long masks disagree");

  // Click and multi-click end a wait; they exclude each other.
  a_end_masks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((click_mask_o & multi_mask_o) == '0)
      && (((click_mask_o | multi_mask_o) & ~awake_mask_o) == '0))
    else $error("click or multi flag outside the waiting phase");

  // A re-press count shows only with its multi flag, and never as zero there.
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((repeat_count_0_o != '0) == multi_mask_o[0])
      && ((repeat_count_1_o != '0) == multi_mask_o[1])
      && ((repeat_count_2_o != '0) == multi_mask_o[2])
      && ((repeat_count_3_o != '0) == multi_mask_o[3]))
    else $error("re-press count does not match multi flag");

endmodule

bind key_click_gesture_detector_top kcgd_checker u_kcgd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .click_mask_o     (click_mask_o),
  .long_mask_o      (long_mask_o),
  .multi_mask_o     (multi_mask_o),
  .repeat_count_0_o (repeat_count_0_o),
  .repeat_count_1_o (repeat_count_1_o),
  .repeat_count_2_o (repeat_count_2_o),
  .repeat_count_3_o (repeat_count_3_o),
  .held_mask_o      (held_mask_o),
  .awake_mask_o     (awake_mask_o)
);

@@ tb/kcgd_gesture_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kcgd_gesture_checker
// Watches the tick, result and register ports of the key gesture detector,
// predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
module kcgd_gesture_checker #(
  parameter int unsigned NumKeys = kcgd_pkg::DefNumKeys
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [kcgd_pkg::TimeW-1:0]    now_ms_i,
  input  logic [kcgd_pkg::MaxKeys-1:0]  key_levels_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [kcgd_pkg::MaxKeys-1:0]  click_mask_i,
  input  logic [kcgd_pkg::MaxKeys-1:0]  long_mask_i,
  input  logic [kcgd_pkg::MaxKeys-1:0]  multi_mask_i,
  input  logic [kcgd_pkg::CountW-1:0]   repeat_count_0_i,
  input  logic [kcgd_pkg::CountW-1:0]   repeat_count_1_i,
  input  logic [kcgd_pkg::CountW-1:0]   repeat_count_2_i,
  input  logic [kcgd_pkg::CountW-1:0]   repeat_count_3_i,
  input  logic [kcgd_pkg::MaxKeys-1:0]  held_mask_i,
  input  logic [kcgd_pkg::MaxKeys-1:0]  awake_mask_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [kcgd_pkg::PaddrW-1:0]   paddr_i,
  input  logic [kcgd_pkg::PdataW-1:0]   pwdata_i,
  input  logic                          pready_i,
  output int                            mismatches_o,
  output int                            ticks_outstanding_o
);

  typedef enum logic [1:0] {
    LaneIdle,
    LaneHeld,
    LaneWaitRepeat,
    LaneLong
  } lane_phase_e;

  typedef struct packed {
    logic [kcgd_pkg::MaxKeys-1:0]                       click;
    logic [kcgd_pkg::MaxKeys-1:0]                       lng;
    logic [kcgd_pkg::MaxKeys-1:0]                       multi;
    logic [kcgd_pkg::MaxKeys-1:0][kcgd_pkg::CountW-1:0] count;
    logic [kcgd_pkg::MaxKeys-1:0]                       held;
    logic [kcgd_pkg::MaxKeys-1:0]                       awake;
  } gesture_word_t;

  logic [kcgd_pkg::CfgW-1:0]   repeat_window;
  logic [kcgd_pkg::CfgW-1:0]   long_press_time;
  lane_phase_e                 lane_phase   [kcgd_pkg::MaxKeys];
  logic [kcgd_pkg::TimeW-1:0]  lane_ref_ms  [kcgd_pkg::MaxKeys];
  logic [kcgd_pkg::CountW-1:0] lane_presses [kcgd_pkg::MaxKeys];
  gesture_word_t               expected_words [$];
  gesture_word_t               want;

  // Advances every key lane by one tick and returns the word it reports.
  function automatic gesture_word_t predict_gestures(
    input logic [kcgd_pkg::TimeW-1:0]   stamp,
    input logic [kcgd_pkg::MaxKeys-1:0] levels);
    gesture_word_t              w;
    logic [kcgd_pkg::TimeW-1:0] elapsed;
    w = '0;
    for (int k = 0; k < NumKeys && k < kcgd_pkg::MaxKeys; k++) begin
      elapsed = stamp - lane_ref_ms[k];
      case (lane_phase[k])
        LaneIdle: begin
          if (levels[k]) begin
            lane_phase[k]  = LaneHeld;
            lane_ref_ms[k] = stamp;
          end
        end
        LaneHeld: begin
          w.held[k] = 1'b1;
          if (!levels[k]) begin
            lane_phase[k]  = LaneWaitRepeat;
            lane_ref_ms[k] = stamp;
          end else if (elapsed >= {16'd0, long_press_time}) begin
            lane_phase[k] = LaneLong;
            w.lng[k]      = 1'b1;
          end
        end
        LaneWaitRepeat: begin
          w.awake[k] = 1'b1;
          // A re-press keeps the release time as reference.
          if (levels[k] && elapsed <= {16'd0, repeat_window}) begin
            lane_phase[k] = LaneHeld;
            if (lane_presses[k] != 8'hFF) lane_presses[k] = lane_presses[k] + 8'd1;
          end else if (elapsed > {16'd0, repeat_window}) begin
            if (lane_presses[k] != 8'd0) begin
              w.multi[k] = 1'b1;
              w.count[k] = lane_presses[k];
            end else begin
              w.click[k] = 1'b1;
            end
            lane_presses[k] = 8'd0;
            lane_phase[k]   = LaneIdle;
          end
        end
        default: begin
          w.awake[k] = 1'b1;
          // Leaving a long press keeps the counter for the next sequence.
          if (!levels[k]) begin
            lane_phase[k]  = LaneIdle;
            lane_ref_ms[k] = stamp;
          end
        end
      endcase
    end
    return w;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_window   = kcgd_pkg::RepeatWindowRst;
      long_press_time = kcgd_pkg::LongPressTimeRst;
      for (int k = 0; k < kcgd_pkg::MaxKeys; k++) begin
        lane_phase[k]   = LaneIdle;
        lane_ref_ms[k]  = '0;
        lane_presses[k] = '0;
      end
      expected_words.delete();
      mismatches_o        = 0;
      ticks_outstanding_o = 0;
    end else begin
      // Results leave before the tick of this edge is predicted.
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("result word arrived with no tick outstanding");
          mismatches_o++;
        end else begin
          want = expected_words.pop_front();
          check_field("click_mask", 8'(want.click), 8'(click_mask_i));
          check_field("long_mask", 8'(want.lng), 8'(long_mask_i));
          check_field("multi_mask", 8'(want.multi), 8'(multi_mask_i));
          check_field("repeat_count_0", want.count[0], repeat_count_0_i);
          check_field("repeat_count_1", want.count[1], repeat_count_1_i);
          check_field("repeat_count_2", want.count[2], repeat_count_2_i);
          check_field("repeat_count_3", want.count[3], repeat_count_3_i);
          check_field("held_mask", 8'(want.held), 8'(held_mask_i));
          check_field("awake_mask", 8'(want.awake), 8'(awake_mask_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_words.push_back(predict_gestures(now_ms_i, key_levels_i));
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == kcgd_pkg::RegRepeatWindow) begin
          repeat_window = pwdata_i[kcgd_pkg::CfgW-1:0];
        end else begin
          long_press_time = pwdata_i[kcgd_pkg::CfgW-1:0];
        end
      end
      ticks_outstanding_o = expected_words.size();
    end
  end

endmodule

@@ tb/key_click_gesture_detector_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_click_gesture_detector_top_tb
// Self-checking bench for the four-key click, multi-click and long-press
// detector.
// ----------------------------------------------------------------------------
// The bench drives poll ticks into the detector and lets a separate checker
// predict every result word and compare it. A short directed part walks
// through a single click, a double click with the re-press right on the
// repeat window, a long press on its exact threshold, a counter carried past
// a long press and a release across the timestamp wrap. Random traffic then
// plays whole gestures with timing placed around the programmed window and
// threshold, mixed with noise ticks, under changing register settings that
// include both extremes. One burst of rapid re-presses on all keys builds up
// large re-press counts.
// ----------------------------------------------------------------------------
module key_click_gesture_detector_top_tb;

  // Cycles without any accepted word before the run is declared hung. The
  // worst correct gap is a run of random stalls and sender gaps.
  localparam int WatchdogLimit = 5000;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic [kcgd_pkg::TimeW-1:0]       now_ms;
  logic [kcgd_pkg::MaxKeys-1:0]     key_levels;
  logic                             out_valid;
  logic                             out_stall;
  logic [kcgd_pkg::MaxKeys-1:0]     click_mask;
  logic [kcgd_pkg::MaxKeys-1:0]     long_mask;
  logic [kcgd_pkg::MaxKeys-1:0]     multi_mask;
  logic [kcgd_pkg::CountW-1:0]      repeat_count_0;
  logic [kcgd_pkg::CountW-1:0]      repeat_count_1;
  logic [kcgd_pkg::CountW-1:0]      repeat_count_2;
  logic [kcgd_pkg::CountW-1:0]      repeat_count_3;
  logic [kcgd_pkg::MaxKeys-1:0]     held_mask;
  logic [kcgd_pkg::MaxKeys-1:0]     awake_mask;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [kcgd_pkg::PaddrW-1:0]      paddr;
  logic [kcgd_pkg::PdataW-1:0]      pwdata;
  logic [kcgd_pkg::PdataW-1:0]      prdata;
  logic                             pready;

  int                               mismatches;
  int                               ticks_outstanding;
  int                               quiet_cycles;
  int                               ticks_sent;
  int                               timing_sets;
  int unsigned                      send_gap_pct;
  int unsigned                      recv_stall_pct;
  // Timing currently programmed; the gesture player aims at these bounds.
  int unsigned                      cur_window;
  int unsigned                      cur_long;
  logic [kcgd_pkg::TimeW-1:0]       clock_ms;

  key_click_gesture_detector_top dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .now_ms_i         (now_ms),
    .key_levels_i     (key_levels),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .click_mask_o     (click_mask),
    .long_mask_o      (long_mask),
    .multi_mask_o     (multi_mask),
    .repeat_count_0_o (repeat_count_0),
    .repeat_count_1_o (repeat_count_1),
    .repeat_count_2_o (repeat_count_2),
    .repeat_count_3_o (repeat_count_3),
    .held_mask_o      (held_mask),
    .awake_mask_o     (awake_mask),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // The checker sees exactly what the detector sees, including every
  // register write, so it keeps its own copy of the timing settings.
  kcgd_gesture_checker checker_i (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .now_ms_i            (now_ms),
    .key_levels_i        (key_levels),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .click_mask_i        (click_mask),
    .long_mask_i         (long_mask),
    .multi_mask_i        (multi_mask),
    .repeat_count_0_i    (repeat_count_0),
    .repeat_count_1_i    (repeat_count_1),
    .repeat_count_2_i    (repeat_count_2),
    .repeat_count_3_i    (repeat_count_3),
    .held_mask_i         (held_mask),
    .awake_mask_i        (awake_mask),
    .psel_i              (psel),
    .penable_i           (penable),
    .pwrite_i            (pwrite),
    .paddr_i             (paddr),
    .pwdata_i            (pwdata),
    .pready_i            (pready),
    .mismatches_o        (mismatches),
    .ticks_outstanding_o (ticks_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver decides afresh at every falling edge whether to hold off
  // the next result word.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Any accepted tick, result word or register write counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offers one tick word, with a random number of idle cycles in front of
  // it, and holds it steady until the detector takes it. Starts and ends at
  // a falling edge; valid stays high for a word that follows directly.
  task automatic drive_tick(input logic [kcgd_pkg::TimeW-1:0] stamp,
                            input logic [kcgd_pkg::MaxKeys-1:0] levels);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    now_ms     <= stamp;
    key_levels <= levels;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    ticks_sent++;
  endtask

  // Stops sending and waits until every predicted word has come back. Each
  // tick yields a word, so once nothing is outstanding the detector is idle.
  task automatic settle();
    in_valid <= 1'b0;
    wait (ticks_outstanding == 0);
    repeat (2) @(negedge clk);
  endtask

  // One register write: setup cycle, then access cycle. The upper data bits
  // carry junk, which the detector must drop.
  task automatic program_reg(input logic index, input logic [kcgd_pkg::CfgW-1:0] value);
    logic [31:0] junk;
    junk = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= {junk[31:16], value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic retime(input int unsigned window, input int unsigned hold);
    settle();
    program_reg(kcgd_pkg::RegRepeatWindow, window[kcgd_pkg::CfgW-1:0]);
    program_reg(kcgd_pkg::RegLongPressTime, hold[kcgd_pkg::CfgW-1:0]);
    cur_window = window;
    cur_long   = hold;
  endtask

  // The first two settings are the extremes; later ones are drawn at random
  // from typical, mixed-extreme and fully random timings.
  task automatic pick_timing();
    case (timing_sets)
      0:       retime(0, 0);
      1:       retime(65535, 65535);
      default: begin
        case ($urandom_range(0, 5))
          0:       retime(300, 3000);
          1:       retime(0, 65535);
          2:       retime(65535, 0);
          3:       retime($urandom_range(0, 400), $urandom_range(0, 4000));
          default: retime($urandom_range(0, 65535), $urandom_range(0, 65535));
        endcase
      end
    endcase
    timing_sets++;
  endtask

  // An offset right at, just below or just above a bound, or somewhere
  // around it, so that the compares in the detector see their edges.
  function automatic logic [kcgd_pkg::TimeW-1:0] near_bound(input int unsigned bound);
    logic [kcgd_pkg::TimeW-1:0] b;
    b = bound;
    case ($urandom_range(0, 5))
      0:       return (b == 0) ? b : b - 1;
      1:       return b;
      2:       return b + 1;
      3:       return $urandom_range(0, bound);
      default: return b + $urandom_range(2, 200);
    endcase
  endfunction

  // One gesture on a random group of keys: one or more presses, some held
  // up to the long-press threshold, re-presses placed around the repeat
  // window, and a tail that mostly lets the window run out. The other keys sit at
  // a fixed random level meanwhile.
  task automatic play_gesture();
    logic [31:0]                rnd;
    logic [3:0]                 keys;
    logic [3:0]                 rest;
    logic [kcgd_pkg::TimeW-1:0] ref_ms;
    int                         presses;
    int                         holds;
    rnd  = $urandom_range(1, 15);
    keys = rnd[3:0];
    rnd  = $urandom;
    rest = ($urandom_range(0, 2) == 0) ? (rnd[3:0] & ~keys) : 4'h0;
    presses = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
    // Now and then start just short of the timestamp wrap.
    if ($urandom_range(0, 9) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
    ref_ms = clock_ms;
    for (int p = 0; p < presses; p++) begin
      if (p == 0) begin
        clock_ms = clock_ms + $urandom_range(1, 40);
      end else begin
        clock_ms = ref_ms + near_bound(cur_window);
      end
      drive_tick(clock_ms, keys | rest);
      // A first press sets the reference; a re-press keeps the release time.
      if (p == 0) ref_ms = clock_ms;
      if ($urandom_range(0, 4) == 0) begin
        clock_ms = ref_ms + near_bound(cur_long);
        drive_tick(clock_ms, keys | rest);
      end
      holds = $urandom_range(0, 3);
      for (int h = 0; h < holds; h++) begin
        clock_ms = clock_ms + $urandom_range(0, 40);
        drive_tick(clock_ms, keys | rest);
      end
      clock_ms = clock_ms + $urandom_range(0, 40);
      drive_tick(clock_ms, rest);
      ref_ms = clock_ms;
    end
    clock_ms = ref_ms + near_bound(cur_window);
    drive_tick(clock_ms, rest);
    if ($urandom_range(0, 3) != 0) begin
      clock_ms = ref_ms + cur_window + 1 + $urandom_range(0, 50);
      drive_tick(clock_ms, rest);
    end
  endtask

  // Mostly whole gestures, the rest short runs of ticks with a random
  // timestamp and random levels. The timing changes every few dozen ticks.
  task automatic run_random(input int count);
    logic [31:0] rnd;
    int          target;
    int          next_retime;
    target      = ticks_sent + count;
    next_retime = ticks_sent;
    while (ticks_sent < target) begin
      if (ticks_sent >= next_retime) begin
        pick_timing();
        next_retime = ticks_sent + $urandom_range(40, 80);
      end
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          clock_ms = $urandom;
          rnd      = $urandom;
          drive_tick(clock_ms, rnd[3:0]);
        end
      end else begin
        play_gesture();
      end
    end
  endtask

  initial begin
    // Every input is known from time zero, and reset is held low at the start.
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    now_ms         = '0;
    key_levels     = '0;
    out_stall      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    quiet_cycles   = 0;
    ticks_sent     = 0;
    timing_sets    = 0;
    send_gap_pct   = 21;
    recv_stall_pct = 57;
    cur_window     = 300;
    cur_long       = 3000;
    clock_ms       = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, at the reset timings of 300 ms and 3000 ms.
    // Key 0: a single click, reported one millisecond after the window.
    drive_tick(32'd10, 4'b0001);
    drive_tick(32'd60, 4'b0000);
    drive_tick(32'd360, 4'b0000);
    drive_tick(32'd361, 4'b0000);
    // Key 1: a double click with the re-press exactly on the window.
    drive_tick(32'd1000, 4'b0010);
    drive_tick(32'd1050, 4'b0000);
    drive_tick(32'd1350, 4'b0010);
    drive_tick(32'd1400, 4'b0000);
    drive_tick(32'd1701, 4'b0000);
    // Key 2: a long press on the exact threshold, then release.
    drive_tick(32'd2000, 4'b0100);
    drive_tick(32'd4999, 4'b0100);
    drive_tick(32'd5000, 4'b0100);
    drive_tick(32'd5100, 4'b0000);
    // Key 3: a re-press held into a long press; the count it leaves behind
    // shows up in the multi-click of the following plain click.
    drive_tick(32'd6000, 4'b1000);
    drive_tick(32'd6050, 4'b0000);
    drive_tick(32'd6100, 4'b1000);
    drive_tick(32'd9049, 4'b1000);
    drive_tick(32'd9050, 4'b1000);
    drive_tick(32'd9100, 4'b0000);
    drive_tick(32'd9200, 4'b1000);
    drive_tick(32'd9250, 4'b0000);
    drive_tick(32'd9551, 4'b0000);
    // All keys: pressed before the timestamp wraps, released after it.
    drive_tick(32'hFFFF_FF00, 4'b1111);
    drive_tick(32'h0000_0010, 4'b0000);
    drive_tick(32'h0000_013D, 4'b0000);
    drive_tick(32'hFFFF_FFFF, 4'b1111);
    clock_ms = 32'hFFFF_FFFF;

    // First random phase: sender gaps are rare, the receiver stalls often.
    run_random(165);

    // Second phase with the roles swapped. It opens with a burst of rapid
    // re-presses on every key, which builds up large re-press counts.
    send_gap_pct   = 57;
    recv_stall_pct = 21;
    retime(300, 3000);
    // Two quiet ticks far apart bring every key back to released.
    clock_ms = clock_ms + 70000;
    drive_tick(clock_ms, 4'b0000);
    clock_ms = clock_ms + 70000;
    drive_tick(clock_ms, 4'b0000);
    repeat (20) begin
      clock_ms = clock_ms + 1;
      drive_tick(clock_ms, 4'b1111);
      clock_ms = clock_ms + 1;
      drive_tick(clock_ms, 4'b0000);
    end
    clock_ms = clock_ms + 301;
    drive_tick(clock_ms, 4'b0000);
    run_random(165);

    // Last phase at full rate on both sides.
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_random(140);

    // Drain, let the output register settle, then judge.
    settle();
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ key_click_gesture_detector_top.f @@
hdl/kcgd_pkg.sv
hdl/kcgd_lane.sv
hdl/kcgd_merge.sv
hdl/key_click_gesture_detector_top.sv
hdl/kcgd_checker.sv
tb/kcgd_gesture_checker.sv
tb/key_click_gesture_detector_top_tb.sv
